FILE: hw/rtl/gwm_pkg.sv
// Shared types and constants for the glob wildcard matcher.
package gwm_pkg;

  parameter int unsigned MaxPatternDef = 32;

  parameter logic [7:0] STAR_CHAR  = 8'h2A;
  parameter logic [7:0] QMARK_CHAR = 8'h3F;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_SUBJECT = 2'd2,
    OP_END     = 2'd3
  } op_e;

  // broadcast to every cell on an accepted beat
  typedef struct packed {
    logic       step;     // any accepted beat
    logic       subject;  // subject character beat
    logic       clear;    // pattern clear beat
    logic [7:0] chr;      // character of the beat
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/gwm_cell.sv
// One pattern position: stored character, valid bit and active bit.
module gwm_cell import gwm_pkg::*; #(
  parameter logic ActRst = 1'b0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       wr_i,
  input  logic       adv_i,
  input  logic       clo_i,
  output logic       adv_o,
  output logic       clo_o,
  output logic       fin_o
);

  logic [7:0] chr_q;
  logic       vld_q, vld_d;
  logic       act_q, act_d;
  logic       is_star, eff_star, hit, stay, raw;

  assign is_star  = (chr_q == STAR_CHAR);
  assign hit      = (chr_q == QMARK_CHAR) || (chr_q == ctrl_i.chr);
  assign eff_star = wr_i ? (ctrl_i.chr == STAR_CHAR) : is_star;
  assign vld_d    = ctrl_i.clear ? 1'b0 : (vld_q | wr_i);

  assign adv_o = ctrl_i.subject & act_q & vld_q & ~is_star & hit;
  assign stay  = ctrl_i.subject & act_q & vld_q & is_star;
  assign raw   = stay | adv_i;
  // stars never sit side by side, so closure spans one position only
  assign clo_o = raw & eff_star & vld_d;
  assign act_d = raw | clo_i;
  assign fin_o = act_q & ~vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      act_q <= ActRst;
    end else if (ctrl_i.step) begin
      vld_q <= vld_d;
      act_q <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      chr_q <= ctrl_i.chr;
    end
  end

endmodule

FILE: hw/rtl/glob_wildcard_matcher_core.sv
// Top level: glob matcher built as a row of position cells.
// Throughput: one beat of any operation per cycle, except while the output register is full and not taken.
// The result beat is registered: it appears in the cycle after its end-of-subject beat is accepted.
// The single output register holds a result until taken; input stalls only while it is full.
// Reset: empty pattern, no overflow, only position zero active, no result pending.
// No clearing pass; the pattern store is valid-tracked per cell.
module glob_wildcard_matcher_core import gwm_pkg::*; #(
  parameter int unsigned MaxPattern = MaxPatternDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_code
  input  logic [1:0] s_axis_tuser,   // [1:0] operation
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

  localparam int unsigned LenW = $clog2(MaxPattern + 1);

  logic            acc;
  op_e             op;
  logic            keep, wr_any;
  logic [LenW-1:0] rlen_q, rlen_d;
  logic [LenW-1:0] clen_q, clen_d;
  logic            last_star_q, last_star_d;
  logic            ovf_q, ovf_d;
  logic            out_vld_q;
  logic [1:0]      out_q;
  cell_ctrl_t      ctrl;

  logic [MaxPattern:0] adv, clo, fin, wr;
  logic [MaxPattern:0] adv_in, clo_in;

  assign s_axis_tready = ~out_vld_q | m_axis_tready;
  assign acc           = s_axis_tvalid & s_axis_tready;
  assign op            = op_e'(s_axis_tuser);

  assign ctrl.step    = acc;
  assign ctrl.subject = acc && (op == OP_SUBJECT);
  assign ctrl.clear   = acc && (op == OP_CLEAR);
  assign ctrl.chr     = s_axis_tdata;

  // repeated stars collapse to one stored star
  assign keep   = (rlen_q != LenW'(MaxPattern)) &&
                  !((s_axis_tdata == STAR_CHAR) && last_star_q);
  assign wr_any = acc && (op == OP_APPEND) && keep;

  always_comb begin
    rlen_d      = rlen_q;
    clen_d      = clen_q;
    last_star_d = last_star_q;
    ovf_d       = ovf_q;
    if (acc) begin
      unique case (op)
        OP_CLEAR: begin
          rlen_d      = '0;
          clen_d      = '0;
          last_star_d = 1'b0;
          ovf_d       = 1'b0;
        end
        OP_APPEND: begin
          if (rlen_q == LenW'(MaxPattern)) begin
            ovf_d = 1'b1;
          end else begin
            rlen_d = rlen_q + LenW'(1);
          end
          if (wr_any) begin
            clen_d      = clen_q + LenW'(1);
            last_star_d = (s_axis_tdata == STAR_CHAR);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rlen_q      <= '0;
      clen_q      <= '0;
      last_star_q <= 1'b0;
      ovf_q       <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      rlen_q      <= rlen_d;
      clen_q      <= clen_d;
      last_star_q <= last_star_d;
      ovf_q       <= ovf_d;
      if (acc && (op == OP_END)) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && (op == OP_END)) begin
      out_q <= {ovf_q, (|fin) & ~ovf_q};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, out_q};

  // position zero reseeds on every beat that is not a subject character
  assign adv_in[0] = acc && (op != OP_SUBJECT);
  assign clo_in[0] = 1'b0;

  for (genvar i = 0; i <= MaxPattern; i++) begin : g_cell
    if (i > 0) begin : g_link
      assign adv_in[i] = adv[i-1];
      assign clo_in[i] = clo[i-1];
    end
    assign wr[i] = wr_any && (clen_q == LenW'(i));

    gwm_cell #(
      .ActRst (i == 0)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .wr_i   (wr[i]),
      .adv_i  (adv_in[i]),
      .clo_i  (clo_in[i]),
      .adv_o  (adv[i]),
      .clo_o  (clo[i]),
      .fin_o  (fin[i])
    );
  end

  a_clen_le_rlen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clen_q <= rlen_q)
    else $error("stored length exceeds pattern length");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (rlen_q == LenW'(MaxPattern)))
    else $error("overflow flagged with room left");

  a_one_end_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(fin))
    else $error("more than one active position past the pattern");

  a_clear_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clear |=> (clen_q == '0) && (rlen_q == '0) && !ovf_q)
    else $error("clear did not empty the pattern");

endmodule

FILE: tb/tb_glob_wildcard_matcher_core.sv
// Self-checking testbench for glob_wildcard_matcher_core: predicts glob verdicts per beat.
`timescale 1ns / 1ps

module tb_glob_wildcard_matcher_core;
  import gwm_pkg::*;

  localparam int unsigned MAX_PAT   = MaxPatternDef;
  localparam int          IDLE_LIMIT = 4000;
  localparam int          RAND_ITEMS = 1300;

  typedef struct {
    op_e        op;
    logic [7:0] chr;
    bit         drain;   // hold off until every verdict has come back
  } beat_t;

  typedef struct packed {
    logic ovf;
    logic hit;
  } verdict_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] char_code
  logic [1:0] s_axis_tuser  = OP_CLEAR; // [1:0] operation
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [0] matched, [1] pattern_overflow, [7:2] zero

  glob_wildcard_matcher_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  beat_t    beat_q[$];
  verdict_t verdict_q[$];
  beat_t    cur_beat;
  verdict_t want;
  int       n_items   = 0;
  int       n_results = 0;
  int       errors    = 0;
  int       tx_gap    = 0;
  int       tx_calm   = 0;
  int       rx_gap    = 0;
  int       rx_calm   = 0;
  int       long_hold = 0;
  int       idle_cnt  = 0;

  // matcher state mirror
  logic [7:0]     pat_mem [MAX_PAT];
  int unsigned    pat_len = 0;
  logic [MAX_PAT:0] live;
  bit             ovf     = 1'b0;

  function automatic logic [MAX_PAT:0] close_stars(logic [MAX_PAT:0] s);
    for (int i = 0; i < pat_len; i++) begin
      if (s[i] && pat_mem[i] == STAR_CHAR) s[i+1] = 1'b1;
    end
    return s;
  endfunction

  function automatic void apply_beat(op_e op, logic [7:0] c);
    logic [MAX_PAT:0] nxt;
    verdict_t v;
    nxt = '0;
    case (op)
      OP_CLEAR: begin
        pat_len = 0;
        ovf = 1'b0;
        live = close_stars((MAX_PAT+1)'(1));
      end
      OP_APPEND: begin
        if (pat_len < MAX_PAT) begin
          pat_mem[pat_len] = c;
          pat_len++;
        end else begin
          ovf = 1'b1;
        end
        live = close_stars((MAX_PAT+1)'(1));
      end
      OP_SUBJECT: begin
        for (int i = 0; i < pat_len; i++) begin
          if (live[i]) begin
            if (pat_mem[i] == STAR_CHAR) nxt[i] = 1'b1;
            else if (pat_mem[i] == QMARK_CHAR || pat_mem[i] == c) nxt[i+1] = 1'b1;
          end
        end
        live = close_stars(nxt);
      end
      default: begin
        v.hit = live[pat_len] && !ovf;
        v.ovf = ovf;
        verdict_q.push_back(v);
        live = close_stars((MAX_PAT+1)'(1));
      end
    endcase
  endfunction

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm = $urandom_range(20, 60);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_lit();
    if ($urandom_range(0, 4) != 0) return 8'h61 + 8'($urandom_range(0, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_beat(op_e op, logic [7:0] c, bit drain = 1'b0);
    beat_t b;
    b.op = op;
    b.chr = c;
    b.drain = drain;
    beat_q.push_back(b);
    n_items++;
  endtask

  // clear, load a pattern, then a few subjects mostly derived from it
  task automatic add_group(bit drain);
    logic [7:0] pat[$];
    logic [7:0] c;
    int plen;
    int r;
    plen = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 8);
    push_beat(OP_CLEAR, 8'($urandom_range(0, 255)), drain);
    for (int i = 0; i < plen; i++) begin
      r = $urandom_range(0, 99);
      c = (r < 25) ? STAR_CHAR : (r < 45) ? QMARK_CHAR : pick_lit();
      pat.push_back(c);
      push_beat(OP_APPEND, c);
    end
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(0, 6)) push_beat(OP_SUBJECT, pick_lit());
      end else begin
        foreach (pat[k]) begin
          if (pat[k] == STAR_CHAR)
            repeat ($urandom_range(0, 3)) push_beat(OP_SUBJECT, pick_lit());
          else if (pat[k] == QMARK_CHAR)
            push_beat(OP_SUBJECT, 8'($urandom_range(0, 255)));
          else if ($urandom_range(0, 19) == 0)
            push_beat(OP_SUBJECT, pick_lit());
          else
            push_beat(OP_SUBJECT, pat[k]);
        end
        if ($urandom_range(0, 9) == 0) push_beat(OP_SUBJECT, pick_lit());
      end
      push_beat(OP_END, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_beat(cur_beat.op, cur_beat.chr);
        tx_gap = pick_gap(tx_calm);
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the beat
      end else if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (beat_q.size() != 0 && !(beat_q[0].drain && verdict_q.size() != 0)) begin
        cur_beat = beat_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cur_beat.chr;
        s_axis_tuser  <= cur_beat.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor and result-side backpressure
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (verdict_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("ERROR: unexpected result beat tdata=%h", m_axis_tdata);
        end else begin
          want = verdict_q.pop_front();
          if (m_axis_tdata !== {6'b0, want.ovf, want.hit}) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: result %0d mismatch: exp matched=%0b overflow=%0b, got tdata=%h",
                       n_results, want.hit, want.ovf, m_axis_tdata);
          end
        end
        rx_gap = pick_gap(rx_calm);
        if (n_results == 40) long_hold = 400;
      end
      if (long_hold > 0) begin
        long_hold--;
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    live = (MAX_PAT+1)'(1);

    // directed
    push_beat(OP_END, 8'h00);          // empty pattern, empty subject
    push_beat(OP_CLEAR, 8'h00);
    push_beat(OP_APPEND, STAR_CHAR);
    push_beat(OP_END, 8'hFF);          // star vs empty subject
    push_beat(OP_SUBJECT, 8'h78);
    push_beat(OP_END, 8'h00);
    push_beat(OP_CLEAR, 8'h55);
    push_beat(OP_APPEND, 8'h61);
    push_beat(OP_APPEND, QMARK_CHAR);
    push_beat(OP_APPEND, 8'hFF);
    push_beat(OP_SUBJECT, 8'h61);
    push_beat(OP_SUBJECT, 8'h00);      // zero byte as a literal
    push_beat(OP_SUBJECT, 8'hFF);
    push_beat(OP_END, 8'h00);
    push_beat(OP_SUBJECT, 8'h61);
    push_beat(OP_APPEND, STAR_CHAR);   // pattern edit mid-subject
    push_beat(OP_SUBJECT, 8'h61);
    push_beat(OP_SUBJECT, 8'h62);
    push_beat(OP_SUBJECT, 8'hFF);
    push_beat(OP_SUBJECT, 8'h7A);
    push_beat(OP_END, 8'h00);
    push_beat(OP_APPEND, 8'h00);
    push_beat(OP_SUBJECT, 8'h01);
    push_beat(OP_END, 8'hAA);
    push_beat(OP_CLEAR, 8'hFF);

    // random: mostly well-formed groups, some noise
    add_group(1'b1);
    while (n_items < RAND_ITEMS + 25) begin
      if ($urandom_range(0, 4) != 0) begin
        add_group($urandom_range(0, 29) == 0);
      end else begin
        repeat ($urandom_range(1, 6))
          push_beat(op_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (beat_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
